>>> rtl/swarq_pkg.sv
// Shared types and constants for the go-back-N sender.
package swarq_pkg;

  localparam int MaxWindow    = 16;
  localparam int QueueDepth   = 64;
  localparam int HoldLimit    = 50;
  localparam int SeqW         = 5;
  localparam int QPtrW        = 6;
  localparam int CntW         = 7;
  localparam int SentW        = 5;

  typedef enum logic [1:0] {
    OP_MSG  = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_CORRUPT  = 2'd2,
    ST_OUTSIDE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_FILL_RD,
    S_FILL_OUT,
    S_RES_RD,
    S_RES_OUT,
    S_FLAG
  } state_e;

  localparam logic [1:0] RegWindow  = 2'd0;
  localparam logic [1:0] RegTimeout = 2'd1;

  typedef struct packed {
    logic    load;
    logic    do_msg;
    logic    do_ack;
    logic    do_tick;
    logic    fill_rd;
    logic    fill_step;
    logic    res_rd;
    logic    res_step;
    logic    res_done;
    logic    ack_done;
    logic    emit_pkt;
    logic    emit_flag;
    status_e flag_status;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic ck_bad;
    logic ack_out;
    logic fill_more;
    logic res_more;
    logic expire;
  } sts_t;

  function automatic logic signed [11:0] byte_sum(input logic [63:0] p);
    logic signed [11:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 12'(signed'(p[8*i +: 8]));
    end
    return s;
  endfunction

endpackage

>>> rtl/swarq_ctrl.sv
// Controller state machine for the go-back-N sender.
module swarq_ctrl import swarq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  logic   out_busy_i,
  input  sts_t   sts_i,
  output cmd_t   cmd_o
);

  state_e  state_q, state_d;
  status_e flag_q, flag_d;
  logic    sent_q, sent_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      flag_q  <= ST_OK;
      sent_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      flag_q  <= flag_d;
      sent_q  <= sent_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    flag_d   = flag_q;
    sent_d   = sent_q;
    cmd_o    = '0;
    cmd_o.flag_status = flag_q;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          flag_d     = ST_OK;
          sent_d     = 1'b0;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (sts_i.op)
          OP_MSG: begin
            if (sts_i.full) begin
              flag_d  = ST_OVERFLOW;
              state_d = S_FLAG;
            end else begin
              cmd_o.do_msg = 1'b1;
              state_d = S_FILL_RD;
            end
          end
          OP_ACK: begin
            if (sts_i.ck_bad) begin
              flag_d  = ST_CORRUPT;
              state_d = S_FLAG;
            end else if (sts_i.ack_out) begin
              flag_d  = ST_OUTSIDE;
              state_d = S_FLAG;
            end else begin
              cmd_o.do_ack = 1'b1;
              state_d = S_FILL_RD;
            end
          end
          OP_TICK: begin
            cmd_o.do_tick = 1'b1;
            state_d = sts_i.expire ? S_RES_RD : S_FLAG;
          end
          default: state_d = S_FLAG;
        endcase
      end
      S_FILL_RD: begin
        if (sts_i.fill_more) begin
          cmd_o.fill_rd = 1'b1;
          state_d = S_FILL_OUT;
        end else begin
          cmd_o.ack_done = 1'b1;
          state_d = sent_q ? S_IDLE : S_FLAG;
        end
      end
      S_FILL_OUT: begin
        if (!out_busy_i) begin
          cmd_o.emit_pkt  = 1'b1;
          cmd_o.fill_step = 1'b1;
          sent_d  = 1'b1;
          state_d = S_FILL_RD;
        end
      end
      S_RES_RD: begin
        if (sts_i.res_more) begin
          cmd_o.res_rd = 1'b1;
          state_d = S_RES_OUT;
        end else begin
          cmd_o.res_done = 1'b1;
          state_d = sent_q ? S_IDLE : S_FLAG;
        end
      end
      S_RES_OUT: begin
        if (!out_busy_i) begin
          cmd_o.emit_pkt = 1'b1;
          cmd_o.res_step = 1'b1;
          sent_d  = 1'b1;
          state_d = S_RES_RD;
        end
      end
      S_FLAG: begin
        if (!out_busy_i) begin
          cmd_o.emit_flag = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> rtl/swarq_dp.sv
// Datapath of the go-back-N sender: stores, pointers, timer and output register.
module swarq_dp import swarq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [1:0]         op_i,
  input  logic [63:0]        payload_i,
  input  logic signed [31:0] in_seq_i,
  input  logic signed [31:0] ack_num_i,
  input  logic signed [31:0] in_checksum_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic               out_busy_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               send_valid_o,
  output logic [4:0]         out_seq_o,
  output logic signed [11:0] out_checksum_o,
  output logic [63:0]        out_payload_o,
  output logic               is_resend_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  logic [4:0]  win_reg_q;
  logic [15:0] tmo_q;
  logic [SeqW-1:0] base_q, next_q, rs_q;
  logic [QPtrW-1:0] head_q, tail_q;
  logic [CntW-1:0] cnt_q;
  logic        t_on_q;
  logic [15:0] t_left_q;
  logic [1:0]  op_q;
  logic [63:0] pay_q;
  logic [31:0] seqf_q, ackf_q, ckf_q;
  logic [63:0] msg_mem [QueueDepth];
  logic [63:0] sent_mem [2*MaxWindow];
  logic [63:0] rd_q;
  logic [SeqW-1:0] pseq_q;

  logic [4:0] w;
  logic [5:0] l;
  logic [5:0] flight, ackoff;
  logic [15:0] tmo_eff;
  logic [31:0] sum32;
  logic [SeqW-1:0] rs_nx;
  logic fill_last_c, res_last_c;

  always_comb begin
    w = win_reg_q;
    if (w == 5'd0) w = 5'd1;
    if (w > 5'(MaxWindow)) w = 5'(MaxWindow);
    l = {w, 1'b0};
    flight = ({1'b0, next_q} >= {1'b0, base_q}) ? 6'({1'b0, next_q} - {1'b0, base_q})
           : 6'({1'b0, next_q} + l - {1'b0, base_q});
    ackoff = (ackf_q[5:0] >= {1'b0, base_q}) ? 6'(ackf_q[5:0] - {1'b0, base_q})
           : 6'(ackf_q[5:0] + l - {1'b0, base_q});
    tmo_eff = (tmo_q == 16'd0) ? 16'd1 : tmo_q;
    sum32 = seqf_q + ackf_q + 32'(byte_sum(pay_q));
  end

  assign rs_nx       = (6'(rs_q) + 6'd1 == l) ? '0 : rs_q + 1'b1;
  assign fill_last_c = !((7'(flight) + 7'd1 < 7'(w)) && (cnt_q > 7'(flight) + 7'd1));
  assign res_last_c  = (rs_nx == next_q);

  assign sts_o.op        = op_e'(op_q);
  assign sts_o.full      = (cnt_q >= CntW'(HoldLimit));
  assign sts_o.ck_bad    = (sum32 != ckf_q);
  assign sts_o.ack_out   = (ackf_q >= 32'(l)) || (ackoff >= flight);
  assign sts_o.fill_more = (flight < 6'(w)) && (cnt_q > 7'(flight));
  assign sts_o.res_more  = (rs_q != next_q);
  assign sts_o.expire    = t_on_q && (t_left_q <= 16'd1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i; pay_q <= payload_i;
      seqf_q <= in_seq_i; ackf_q <= ack_num_i; ckf_q <= in_checksum_i;
    end
    if (cmd_i.do_msg && !sts_o.full) msg_mem[tail_q] <= pay_q;
    if (cmd_i.fill_rd) begin
      rd_q <= msg_mem[head_q];
      pseq_q <= next_q;
    end
    if (cmd_i.fill_step) sent_mem[next_q] <= rd_q;
    if (cmd_i.res_rd) begin
      rd_q <= sent_mem[rs_q];
      pseq_q <= rs_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_reg_q <= 5'd4; tmo_q <= 16'd20;
      base_q <= '0; next_q <= '0; rs_q <= '0;
      head_q <= '0; tail_q <= '0; cnt_q <= '0;
      t_on_q <= 1'b0; t_left_q <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == RegWindow) begin
        cnt_q <= (cnt_q >= 7'(flight)) ? cnt_q - 7'(flight) : '0;
        win_reg_q <= cfg_data_i[4:0];
        base_q <= '0; next_q <= '0; t_on_q <= 1'b0; t_left_q <= '0;
      end
      if (cfg_we_i && cfg_idx_i == RegTimeout) tmo_q <= cfg_data_i;
      if (cmd_i.do_msg) begin
        tail_q <= tail_q + 1'b1;
        cnt_q  <= cnt_q + 1'b1;
      end
      if (cmd_i.do_ack) begin
        base_q <= (ackf_q[5:0] + 6'd1 == l) ? '0 : SeqW'(ackf_q[5:0] + 6'd1);
        cnt_q  <= (cnt_q >= 7'(ackoff) + 7'd1) ? cnt_q - 7'(ackoff) - 7'd1 : '0;
        t_on_q <= 1'b0;
      end
      if (cmd_i.fill_rd && flight == 6'd0 && !t_on_q) begin
        t_on_q <= 1'b1; t_left_q <= tmo_eff;
      end
      if (cmd_i.fill_step) begin
        head_q <= head_q + 1'b1;
        next_q <= (6'(next_q) + 6'd1 == l) ? '0 : next_q + 1'b1;
      end
      if (cmd_i.ack_done && op_q == OP_ACK && flight != 6'd0) begin
        t_on_q <= 1'b1; t_left_q <= tmo_eff;
      end
      if (cmd_i.do_tick && t_on_q) begin
        t_left_q <= (t_left_q != 16'd0) ? t_left_q - 16'd1 : '0;
        rs_q <= base_q;
      end
      if (cmd_i.res_step) rs_q <= rs_nx;
      if (cmd_i.res_done) begin
        t_on_q <= (flight != 6'd0);
        t_left_q <= tmo_eff;
      end
    end
  end

  // output register
  logic ov_q;
  logic resend_c;
  assign resend_c = (op_q == OP_TICK);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit_pkt || cmd_i.emit_flag) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  logic [4:0] sq_q; logic signed [11:0] ck_q; logic [63:0] po_q;
  logic sv_q, rsd_q, lst_q; logic [1:0] st_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_pkt) begin
      sv_q <= 1'b1; sq_q <= pseq_q; po_q <= rd_q;
      ck_q <= 12'(pseq_q) + byte_sum(rd_q);
      rsd_q <= resend_c; st_q <= ST_OK;
      lst_q <= resend_c ? res_last_c : fill_last_c;
    end else if (cmd_i.emit_flag) begin
      sv_q <= 1'b0; sq_q <= '0; po_q <= '0; ck_q <= '0;
      rsd_q <= 1'b0; st_q <= cmd_i.flag_status; lst_q <= 1'b1;
    end
  end

  assign out_valid_o = ov_q;
  assign out_busy_o = ov_q && out_stall_i;
  assign send_valid_o = sv_q;
  assign out_seq_o = sq_q;
  assign out_checksum_o = ck_q;
  assign out_payload_o = po_q;
  assign is_resend_o = rsd_q;
  assign status_o = st_q;
  assign last_o = lst_q;

endmodule

>>> rtl/sliding_window_arq_sender.sv
// Top level of the go-back-N sender.
// An accepted item passes the decide state, then a store read or the flag state, before
// its first result is registered. Items do not overlap: in_stall_o holds a new item until
// the last one is done, and each packet waits on output stalls. This is set by the
// single-port message and sent-packet stores and the shared output register.
// Reset: asynchronous, active low; window 4, timeout 20, queue and window empty.
module sliding_window_arq_sender import swarq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [63:0]        payload_i,
  input  logic signed [31:0] in_seq_i,
  input  logic signed [31:0] ack_num_i,
  input  logic signed [31:0] in_checksum_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               send_valid_o,
  output logic [4:0]         out_seq_o,
  output logic signed [11:0] out_checksum_o,
  output logic [63:0]        out_payload_o,
  output logic               is_resend_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  cmd_t cmd;
  sts_t sts;
  logic busy;

  swarq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .out_busy_i(busy), .sts_i(sts), .cmd_o(cmd)
  );

  swarq_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .op_i, .payload_i, .in_seq_i, .ack_num_i, .in_checksum_i,
    .cmd_i(cmd), .sts_o(sts), .out_busy_o(busy),
    .out_valid_o, .out_stall_i,
    .send_valid_o, .out_seq_o, .out_checksum_o, .out_payload_o,
    .is_resend_o, .status_o, .last_o
  );

endmodule
